// File: rtl/ifsc_pkg.sv
// shared constants for the sync-headed frame checker
`timescale 1ns / 1ps

package ifsc_pkg;

  // default frame length in bytes (legal range 6 to 64)
  localparam int FRAME_BYTES_DEF = 56;

  // sync pair, header and tail byte values
  localparam logic [7:0] SYNC_FIRST  = 8'hAA;
  localparam logic [7:0] SYNC_SECOND = 8'h55;
  localparam logic [7:0] HDR_BYTE2   = 8'h02;
  localparam logic [7:0] HDR_BYTE3   = 8'h36;
  localparam logic [7:0] TAIL_BYTE   = 8'h5A;

  // per-beat status codes
  localparam logic [1:0] ST_PENDING = 2'd0;
  localparam logic [1:0] ST_VALID   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

endpackage

// File: rtl/imu_frame_sync_checker.sv
// top level: byte-stream frame sync, header, tail and sum8 checker
`timescale 1ns / 1ps

// Takes one received byte per input beat and returns one result beat per byte:
// status (pending, frame valid, frame invalid), whether the byte was placed in
// the frame, its frame offset and the byte itself. The block hunts for the
// sync pair 0xAA 0x55, collects FRAME_BYTES bytes, checks bytes 2 and 3
// against 0x02 0x36, the last byte against 0x5A and the wrapping 8-bit sum of
// bytes 2 through FRAME_BYTES-3 against byte FRAME_BYTES-2. An invalid frame
// is not rescanned. Throughput is one byte per clock while out_ready is high;
// each byte passes through the input register, the combinational frame-state
// update and then the result register. in_ready depends combinationally on
// out_ready through the two-entry pipeline.
module imu_frame_sync_checker
  import ifsc_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_status,
  output logic       out_stored,
  output logic [5:0] out_position,
  output logic [7:0] out_frame_byte
);

  localparam logic [5:0] LAST_POS = 6'(FRAME_BYTES - 1);
  localparam logic [5:0] SUM_POS  = 6'(FRAME_BYTES - 2);
  localparam logic [5:0] SUM_END  = 6'(FRAME_BYTES - 3);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       out_valid_r;
  logic [1:0] status_r, status_nxt;
  logic       stored_r, stored_nxt;
  logic [5:0] pos_r, pos_nxt;
  logic [7:0] fbyte_r;
  logic [5:0] fill_r, fill_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic       hdr_r, hdr_nxt;
  logic [7:0] exp_r, exp_nxt;
  logic       advance;
  logic       frame_ok;

  // pipeline handshake
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_data_byte;
    end
  end

  // frame state update for the byte in the input register
  always_comb begin
    status_nxt = ST_PENDING;
    stored_nxt = 1'b0;
    pos_nxt    = 6'd0;
    fill_nxt   = fill_r;
    sum_nxt    = sum_r;
    hdr_nxt    = hdr_r;
    exp_nxt    = exp_r;
    frame_ok   = 1'b0;
    if (fill_r == 6'd0) begin
      // hunting for first sync byte
      if (in_byte_r == SYNC_FIRST) begin
        stored_nxt = 1'b1;
        fill_nxt   = 6'd1;
      end
    end else if (fill_r == 6'd1) begin
      // waiting for second sync byte
      if (in_byte_r == SYNC_SECOND) begin
        stored_nxt = 1'b1;
        pos_nxt    = 6'd1;
        fill_nxt   = 6'd2;
        sum_nxt    = 8'd0;
        hdr_nxt    = 1'b1;
      end else if (in_byte_r == SYNC_FIRST) begin
        stored_nxt = 1'b1;
        fill_nxt   = 6'd1;
      end else begin
        fill_nxt = 6'd0;
      end
    end else begin
      // frame body
      stored_nxt = 1'b1;
      pos_nxt    = fill_r;
      if (fill_r == 6'd2 && in_byte_r != HDR_BYTE2) begin
        hdr_nxt = 1'b0;
      end
      if (fill_r == 6'd3 && in_byte_r != HDR_BYTE3) begin
        hdr_nxt = 1'b0;
      end
      if (fill_r <= SUM_END) begin
        sum_nxt = sum_r + in_byte_r;
      end
      if (fill_r == SUM_POS) begin
        exp_nxt = in_byte_r;
      end
      if (fill_r >= LAST_POS) begin
        frame_ok   = hdr_nxt && (in_byte_r == TAIL_BYTE) && (sum_nxt == exp_nxt);
        status_nxt = frame_ok ? ST_VALID : ST_INVALID;
        fill_nxt   = 6'd0;
        sum_nxt    = 8'd0;
        hdr_nxt    = 1'b1;
      end else begin
        fill_nxt = fill_r + 6'd1;
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= 6'd0;
      sum_r  <= 8'd0;
      hdr_r  <= 1'b1;
      exp_r  <= 8'd0;
    end else if (in_valid_r && advance) begin
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
      hdr_r  <= hdr_nxt;
      exp_r  <= exp_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_r && advance) begin
      status_r <= status_nxt;
      stored_r <= stored_nxt;
      pos_r    <= pos_nxt;
      fbyte_r  <= in_byte_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_stored     = stored_r;
  assign out_position   = pos_r;
  assign out_frame_byte = fbyte_r;

endmodule

// File: rtl/ifsc_checker.sv
// port-level checks for the frame checker, bound to the top level
`timescale 1ns / 1ps

module ifsc_checker
  import ifsc_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_status,
  input logic       out_stored,
  input logic [5:0] out_position,
  input logic [7:0] out_frame_byte
);

  localparam logic [5:0] LAST_POS = 6'(FRAME_BYTES - 1);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_stored) && $stable(out_position) && $stable(out_frame_byte))
    else $error("result beat changed while stalled");

  // dropped bytes carry offset zero
  a_drop_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stored |-> out_position == 6'd0 && out_status == ST_PENDING)
    else $error("dropped byte with nonzero offset or final status");

  // a final status only on the last frame byte
  a_final_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_VALID || out_status == ST_INVALID) |->
    out_stored && out_position == LAST_POS)
    else $error("final status away from last frame offset");

  // a valid frame always ends on the tail byte
  a_valid_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_VALID |-> out_frame_byte == TAIL_BYTE)
    else $error("valid frame without tail byte");

  // no reserved status code
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_PENDING || out_status == ST_VALID ||
    out_status == ST_INVALID)
    else $error("reserved status code");

endmodule

bind imu_frame_sync_checker ifsc_checker #(
  .FRAME_BYTES(FRAME_BYTES)
) u_ifsc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_stored    (out_stored),
  .out_position  (out_position),
  .out_frame_byte(out_frame_byte)
);
